@@ rtl/tsi_pkg.sv @@
// ----------------------------------------------------------------------------
// tsi_pkg
// Shared types and constants for the timed scroll interpolator.
// ----------------------------------------------------------------------------
package tsi_pkg;

    localparam int POS_W  = 16;
    localparam int FINE_W = 3;
    localparam int FUNC_W = 3;
    localparam int IN_W   = 64;
    localparam int OUT_W  = 40;

    localparam logic [FINE_W-1:0] FINE_MAX    = 3'd7;
    localparam logic [POS_W-1:0]  ELAPSED_MAX = 16'hFFFF;

    // Command codes carried on s_tuser
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK   = 3'd0,
        FUNC_START  = 3'd1,
        FUNC_SET_X  = 3'd2,
        FUNC_SET_Y  = 3'd3,
        FUNC_FINE_X = 3'd4,
        FUNC_FINE_Y = 3'd5,
        FUNC_RESET  = 3'd6
    } func_t;

    // Request to the shared multiply/divide unit
    typedef struct packed {
        logic             start;
        logic [POS_W-1:0] mag;
        logic [POS_W-1:0] mult;
        logic [POS_W-1:0] divisor;
    } div_req_t;

    // Response from the shared multiply/divide unit
    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] quo;
    } div_rsp_t;

endpackage

@@ rtl/tsi_div.sv @@
// ----------------------------------------------------------------------------
// tsi_div
// Shared unit: one registered 16x16 multiply, then a restoring divide that
// retires one quotient bit per cycle. Requires mag*mult < 2^16 * divisor.
// ----------------------------------------------------------------------------
module tsi_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  tsi_pkg::div_req_t  req,
    output tsi_pkg::div_rsp_t  rsp
);

    localparam int W = tsi_pkg::POS_W;

    logic               busy_reg;
    logic               done_reg;
    logic [3:0]         cnt_reg;
    logic [W-1:0]       rem_reg;
    logic [W-1:0]       quo_reg;

    logic [2*W-1:0]     prod;
    logic [W:0]         shifted;
    logic [W:0]         trial;
    logic               fits;

    assign prod    = (2*W)'(req.mag) * (2*W)'(req.mult);
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign trial   = shifted - {1'b0, req.divisor};
    assign fits    = shifted >= {1'b0, req.divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'(W-1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Upper product half is already below the divisor, so remainder stays 16 bits
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= prod[2*W-1:W];
            quo_reg <= prod[W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[W-1:0] : shifted[W-1:0];
            quo_reg <= {quo_reg[W-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

@@ rtl/timed_scroll_interpolator.sv @@
// Set, fine, reset, start-move, idle-tick and snapping-tick commands
//   land in the output register in the cycle after the input beat.
// An interpolating tick goes through an issue step, then per axis a load step
//   with the multiply, 16 divide steps and a done step of the shared unit.
// One command at a time: the next beat waits for an idle sequencer and a free
//   or draining output register. Reset (rst_n, async): all state zero but m_tdata.
// ----------------------------------------------------------------------------
// timed_scroll_interpolator
// Display scroll unit: X/Y scroll positions with fine offsets and a timed
// linear move, advanced by millisecond ticks. One result beat per command.
// ----------------------------------------------------------------------------
module timed_scroll_interpolator
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [15:0] dest_x, [31:16] dest_y, [47:32] time_ms, [63:48] value
    input  logic [tsi_pkg::IN_W-1:0]     s_tdata,
    // [2:0] func
    input  logic [tsi_pkg::FUNC_W-1:0]   s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [15:0] scroll_x, [31:16] scroll_y, [34:32] fine_x_out,
    // [37:35] fine_y_out, [38] moving, [39] tick_applied
    output logic [tsi_pkg::OUT_W-1:0]    m_tdata
);

    localparam int W  = tsi_pkg::POS_W;
    localparam int FW = tsi_pkg::FINE_W;

    // Sequencer: idle, then issue/wait on the shared unit for X, then for Y
    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_START_X = 5'b00010,
        ST_WAIT_X  = 5'b00100,
        ST_START_Y = 5'b01000,
        ST_WAIT_Y  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [W-1:0]  pos_x_reg, pos_x_next;
    logic [W-1:0]  pos_y_reg, pos_y_next;
    logic [FW-1:0] fine_x_reg, fine_x_next;
    logic [FW-1:0] fine_y_reg, fine_y_next;
    logic [W-1:0]  start_x_reg, start_x_next;
    logic [W-1:0]  start_y_reg, start_y_next;
    logic [W-1:0]  goal_x_reg, goal_x_next;
    logic [W-1:0]  goal_y_reg, goal_y_next;
    logic [W-1:0]  dur_reg, dur_next;
    logic [W-1:0]  elapsed_reg, elapsed_next;
    logic          active_reg, active_next;
    logic          out_valid_reg, out_valid_next;
    logic [tsi_pkg::OUT_W-1:0] out_data_reg, out_data_next;

    // Input beat fields
    logic [W-1:0]  in_tx, in_ty, in_tms, in_val;
    tsi_pkg::func_t in_func;
    logic          accept;

    // Tick arithmetic
    logic [W:0]    e_sum;
    logic [W-1:0]  e_sat;
    logic [FW-1:0] val_clamped;

    // Shared-axis interpolation
    logic          sel_y;
    logic [W-1:0]  ax_start, ax_goal;
    logic [W:0]    ax_diff, ax_mag;
    logic          ax_neg;
    logic [W-1:0]  ax_q, ax_new;

    logic          load_out;
    logic          applied;

    tsi_pkg::div_req_t div_req;
    tsi_pkg::div_rsp_t div_rsp;

    assign in_tx   = s_tdata[15:0];
    assign in_ty   = s_tdata[31:16];
    assign in_tms  = s_tdata[47:32];
    assign in_val  = s_tdata[63:48];
    assign in_func = tsi_pkg::func_t'(s_tuser);

    // Take a beat only when idle and the output slot is empty or draining
    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // Elapsed time saturates at the top of its range
    assign e_sum = {1'b0, elapsed_reg} + {1'b0, in_tms};
    assign e_sat = e_sum[W] ? tsi_pkg::ELAPSED_MAX : e_sum[W-1:0];

    // Clamp a signed fine offset to 0..7
    always_comb
    begin
        priority if (in_val[W-1])
            val_clamped = '0;
        else if (in_val > W'(tsi_pkg::FINE_MAX))
            val_clamped = tsi_pkg::FINE_MAX;
        else
            val_clamped = in_val[FW-1:0];
    end

    // One axis at a time goes through the shared unit as |goal-start|*elapsed/dur;
    // the sign is put back afterwards, which truncates toward zero
    assign sel_y    = (state_reg == ST_START_Y) || (state_reg == ST_WAIT_Y);
    assign ax_start = sel_y ? start_y_reg : start_x_reg;
    assign ax_goal  = sel_y ? goal_y_reg  : goal_x_reg;
    assign ax_diff  = {ax_goal[W-1], ax_goal} - {ax_start[W-1], ax_start};
    assign ax_neg   = ax_diff[W];
    assign ax_mag   = ax_neg ? (~ax_diff + (W+1)'(1)) : ax_diff;
    assign ax_q     = ax_neg ? (~div_rsp.quo + W'(1)) : div_rsp.quo;
    assign ax_new   = ax_start + ax_q;

    assign div_req.start   = (state_reg == ST_START_X) || (state_reg == ST_START_Y);
    assign div_req.mag     = ax_mag[W-1:0];
    assign div_req.mult    = elapsed_reg;
    assign div_req.divisor = dur_reg;

    tsi_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next   = state_reg;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        fine_x_next  = fine_x_reg;
        fine_y_next  = fine_y_reg;
        start_x_next = start_x_reg;
        start_y_next = start_y_reg;
        goal_x_next  = goal_x_reg;
        goal_y_next  = goal_y_reg;
        dur_next     = dur_reg;
        elapsed_next = elapsed_reg;
        active_next  = active_reg;
        load_out     = 1'b0;
        applied      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_func)
                        tsi_pkg::FUNC_TICK:
                        begin
                            if (active_reg)
                            begin
                                elapsed_next = e_sat;
                                fine_x_next  = '0;
                                fine_y_next  = '0;
                                if (e_sat >= dur_reg)
                                begin
                                    // Move has run its course: snap to the goal
                                    pos_x_next  = goal_x_reg;
                                    pos_y_next  = goal_y_reg;
                                    active_next = 1'b0;
                                    load_out    = 1'b1;
                                    applied     = 1'b1;
                                end
                                else
                                begin
                                    state_next = ST_START_X;
                                end
                            end
                            else
                            begin
                                load_out = 1'b1;
                            end
                        end
                        tsi_pkg::FUNC_START:
                        begin
                            goal_x_next  = in_tx;
                            goal_y_next  = in_ty;
                            start_x_next = pos_x_reg;
                            start_y_next = pos_y_reg;
                            dur_next     = in_tms;
                            elapsed_next = '0;
                            active_next  = 1'b1;
                            load_out     = 1'b1;
                        end
                        tsi_pkg::FUNC_SET_X:
                        begin
                            pos_x_next  = in_val;
                            fine_x_next = '0;
                            load_out    = 1'b1;
                        end
                        tsi_pkg::FUNC_SET_Y:
                        begin
                            pos_y_next  = in_val;
                            fine_y_next = '0;
                            load_out    = 1'b1;
                        end
                        tsi_pkg::FUNC_FINE_X:
                        begin
                            fine_x_next = val_clamped;
                            load_out    = 1'b1;
                        end
                        tsi_pkg::FUNC_FINE_Y:
                        begin
                            fine_y_next = val_clamped;
                            load_out    = 1'b1;
                        end
                        tsi_pkg::FUNC_RESET:
                        begin
                            pos_x_next  = '0;
                            pos_y_next  = '0;
                            fine_x_next = '0;
                            fine_y_next = '0;
                            active_next = 1'b0;
                            load_out    = 1'b1;
                        end
                        default:
                        begin
                            // Unused code: report unchanged state
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_START_X:
            begin
                state_next = ST_WAIT_X;
            end
            ST_WAIT_X:
            begin
                if (div_rsp.done)
                begin
                    pos_x_next = ax_new;
                    state_next = ST_START_Y;
                end
            end
            ST_START_Y:
            begin
                state_next = ST_WAIT_Y;
            end
            ST_WAIT_Y:
            begin
                if (div_rsp.done)
                begin
                    pos_y_next = ax_new;
                    load_out   = 1'b1;
                    applied    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: load the post-command state, drop it once taken
    always_comb
    begin
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {applied, active_next, fine_y_next, fine_x_next,
                              pos_y_next, pos_x_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            fine_x_reg    <= '0;
            fine_y_reg    <= '0;
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            goal_x_reg    <= '0;
            goal_y_reg    <= '0;
            dur_reg       <= '0;
            elapsed_reg   <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            fine_x_reg    <= fine_x_next;
            fine_y_reg    <= fine_y_next;
            start_x_reg   <= start_x_next;
            start_y_reg   <= start_y_next;
            goal_x_reg    <= goal_x_next;
            goal_y_reg    <= goal_y_next;
            dur_reg       <= dur_next;
            elapsed_reg   <= elapsed_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ rtl/tsi_checker.sv @@
// ----------------------------------------------------------------------------
// tsi_checker
// Port-level checks for the timed scroll interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module tsi_checker
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [tsi_pkg::OUT_W-1:0] m_tdata
);

    // A beat is never taken while a result sits stalled
    a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> !(m_tvalid && !m_tready))
        else $error("input beat taken while output stalled");

    // A tick that moved the position clears both fine offsets
    a_tick_clears_fine: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[39]) |-> (m_tdata[37:32] == 6'd0))
        else $error("applied tick left a fine offset set");

    // A stalled result stays offered
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("output beat withdrawn while stalled");

    // A stalled result keeps its payload
    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("output payload changed while stalled");

endmodule

bind timed_scroll_interpolator tsi_checker u_tsi_checker (.*);

@@ tb/timed_scroll_interpolator_tb.sv @@
// ----------------------------------------------------------------------------
// timed_scroll_interpolator_tb
// Self-checking bench for the scroll interpolator. A short command table
// covers the corner cases first. Random move sequences follow, run under four
// handshake pressure phases. Every result beat is checked, field by field,
// against an in-bench model of the scroll state or a typed-in table result.
// ----------------------------------------------------------------------------
module timed_scroll_interpolator_tb;

    localparam int          POS_W        = tsi_pkg::POS_W;
    localparam int          FINE_W       = tsi_pkg::FINE_W;
    localparam int          FUNC_W       = tsi_pkg::FUNC_W;
    localparam int          IN_W         = tsi_pkg::IN_W;
    localparam int          OUT_W        = tsi_pkg::OUT_W;
    localparam int          HALF_PERIOD  = 5;
    localparam int          RESET_CYCLES = 12;
    localparam int          RANDOM_ITEMS = 1750;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 50;
    localparam int          STALL_LIMIT  = 4000;
    localparam int          REPORT_MAX   = 10;
    // func code seven has no command behind it and must be ignored
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;

    // One command beat, fields as they travel on s_tdata / s_tuser
    typedef struct {
        logic [FUNC_W-1:0] op;
        logic [POS_W-1:0]  tx;
        logic [POS_W-1:0]  ty;
        logic [POS_W-1:0]  tms;
        logic [POS_W-1:0]  val;
    } scroll_cmd_t;

    // One result beat, laid out as m_tdata from bit 39 down to bit 0
    typedef struct packed {
        logic              tick_applied;
        logic              moving;
        logic [FINE_W-1:0] fine_y;
        logic [FINE_W-1:0] fine_x;
        logic [POS_W-1:0]  y;
        logic [POS_W-1:0]  x;
    } scroll_view_t;

    // Directed table row: a command and, where obvious, its typed-in result
    typedef struct {
        scroll_cmd_t  cmd;
        bit           fixed;
        scroll_view_t view;
    } table_row_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic [FUNC_W-1:0] s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;

    timed_scroll_interpolator dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------------
    // Scroll state mirror, advanced once per accepted command beat
    // ------------------------------------------------------------------------
    logic signed [POS_W-1:0] mir_px, mir_py;
    logic signed [POS_W-1:0] mir_sx, mir_sy;
    logic signed [POS_W-1:0] mir_gx, mir_gy;
    logic [FINE_W-1:0]       mir_fx, mir_fy;
    logic [POS_W-1:0]        mir_dur, mir_elapsed;
    logic                    mir_active;

    scroll_view_t view_queue[$];
    table_row_t   cmd_table[$];

    // Beat currently on the slave side and its typed-in result, if any
    bit           beat_fixed;
    scroll_view_t beat_view;

    int unsigned gap_pct;
    int unsigned stall_pct;
    int unsigned hold_requests;
    int unsigned idle_cycles;
    int unsigned mismatches;
    int unsigned failures;
    int unsigned cmds_taken;
    int unsigned results_checked;
    int unsigned lerp_ticks;
    int unsigned snap_ticks;
    int unsigned idle_ticks;
    int unsigned moves_started;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------------
    // Interpolation and state update
    // ------------------------------------------------------------------------
    // start + trunc((goal - start) * elapsed / duration); only called with
    // elapsed < duration, so the divisor is never zero
    function automatic logic [POS_W-1:0] lerp_axis(logic signed [POS_W-1:0] s,
                                                   logic signed [POS_W-1:0] g);
        longint span;
        longint step;
        span = longint'(g) - longint'(s);
        step = (span * longint'(mir_elapsed)) / longint'(mir_dur);
        return POS_W'(longint'(s) + step);
    endfunction

    function automatic logic [FINE_W-1:0] clamp_fine(logic [POS_W-1:0] raw);
        if ($signed(raw) < 0)
            return '0;
        if ($signed(raw) > 7)
            return tsi_pkg::FINE_MAX;
        return raw[FINE_W-1:0];
    endfunction

    function automatic scroll_view_t advance_scroll(scroll_cmd_t c);
        scroll_view_t v;
        logic [POS_W:0] sum;
        logic           applied;
        applied = 1'b0;
        case (c.op)
            tsi_pkg::FUNC_TICK:
            begin
                if (mir_active)
                begin
                    // saturate elapsed so long moves never wrap back
                    sum = {1'b0, mir_elapsed} + {1'b0, c.tms};
                    mir_elapsed = sum[POS_W] ? tsi_pkg::ELAPSED_MAX : sum[POS_W-1:0];
                    if (mir_elapsed >= mir_dur)
                    begin
                        mir_px = mir_gx;
                        mir_py = mir_gy;
                        mir_active = 1'b0;
                        snap_ticks++;
                    end
                    else
                    begin
                        mir_px = lerp_axis(mir_sx, mir_gx);
                        mir_py = lerp_axis(mir_sy, mir_gy);
                        lerp_ticks++;
                    end
                    mir_fx = '0;
                    mir_fy = '0;
                    applied = 1'b1;
                end
                else
                    idle_ticks++;
            end
            tsi_pkg::FUNC_START:
            begin
                mir_gx = c.tx;
                mir_gy = c.ty;
                mir_sx = mir_px;
                mir_sy = mir_py;
                mir_dur = c.tms;
                mir_elapsed = '0;
                mir_active = 1'b1;
                moves_started++;
            end
            tsi_pkg::FUNC_SET_X:
            begin
                mir_px = c.val;
                mir_fx = '0;
            end
            tsi_pkg::FUNC_SET_Y:
            begin
                mir_py = c.val;
                mir_fy = '0;
            end
            tsi_pkg::FUNC_FINE_X: mir_fx = clamp_fine(c.val);
            tsi_pkg::FUNC_FINE_Y: mir_fy = clamp_fine(c.val);
            tsi_pkg::FUNC_RESET:
            begin
                mir_px = '0;
                mir_py = '0;
                mir_fx = '0;
                mir_fy = '0;
                mir_active = 1'b0;
            end
            default: ;
        endcase
        v.x = mir_px;
        v.y = mir_py;
        v.fine_x = mir_fx;
        v.fine_y = mir_fy;
        v.moving = mir_active;
        v.tick_applied = applied;
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: check result beats, then predict from command beats
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        scroll_view_t got;
        scroll_view_t want;
        scroll_view_t predicted;
        scroll_cmd_t  c;
        bit           moved;
        if (rst_n)
        begin
            moved = 1'b0;
            // check first: a result can never belong to the beat taken this edge
            if (m_tvalid && m_tready)
            begin
                moved = 1'b1;
                got = scroll_view_t'(m_tdata);
                if (view_queue.size() == 0)
                begin
                    failures++;
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected result beat: x=%h y=%h fx=%0d fy=%0d mv=%b ta=%b",
                                 got.x, got.y, got.fine_x, got.fine_y, got.moving,
                                 got.tick_applied);
                end
                else
                begin
                    want = view_queue.pop_front();
                    results_checked++;
                    if (got !== want)
                    begin
                        failures++;
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                        begin
                            $display("mismatch on result %0d:", results_checked);
                            $display("  expected x=%h y=%h fx=%0d fy=%0d mv=%b ta=%b",
                                     want.x, want.y, want.fine_x, want.fine_y,
                                     want.moving, want.tick_applied);
                            $display("  actual   x=%h y=%h fx=%0d fy=%0d mv=%b ta=%b",
                                     got.x, got.y, got.fine_x, got.fine_y,
                                     got.moving, got.tick_applied);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                moved = 1'b1;
                c.op  = s_tuser;
                c.tx  = s_tdata[15:0];
                c.ty  = s_tdata[31:16];
                c.tms = s_tdata[47:32];
                c.val = s_tdata[63:48];
                predicted = advance_scroll(c);
                // a typed-in table result takes precedence over the mirror
                view_queue.push_back(beat_fixed ? beat_view : predicted);
                cmds_taken++;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long
    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("watchdog: no beat for %0d cycles, %0d results still expected",
                 STALL_LIMIT, view_queue.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int unsigned hold_served;
        int unsigned hold_left;
        hold_served = 0;
        hold_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != hold_served)
            begin
                hold_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_pct != 0 && $urandom_range(99) < stall_pct)
                m_tready <= 1'b0;
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------------
    // Entered and left at a falling edge; hold the beat until it is taken
    task automatic send_cmd(scroll_cmd_t c, bit fixed, scroll_view_t v);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        beat_fixed = fixed;
        beat_view = v;
        s_tvalid <= 1'b1;
        s_tdata <= {c.val, c.tms, c.ty, c.tx};
        s_tuser <= c.op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid and pause until every outstanding result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (view_queue.size() != 0)
            @(negedge clk);
    endtask

    function automatic scroll_view_t view_of(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                             int unsigned fx, int unsigned fy,
                                             int unsigned mv, int unsigned ta);
        scroll_view_t v;
        v.x = x;
        v.y = y;
        v.fine_x = FINE_W'(fx);
        v.fine_y = FINE_W'(fy);
        v.moving = mv[0];
        v.tick_applied = ta[0];
        return v;
    endfunction

    task automatic add_row(logic [FUNC_W-1:0] op, logic [POS_W-1:0] tx,
                           logic [POS_W-1:0] ty, logic [POS_W-1:0] tms,
                           logic [POS_W-1:0] val, int unsigned fixed, scroll_view_t v);
        table_row_t r;
        r.cmd.op = op;
        r.cmd.tx = tx;
        r.cmd.ty = ty;
        r.cmd.tms = tms;
        r.cmd.val = val;
        r.fixed = (fixed != 0);
        r.view = v;
        cmd_table.push_back(r);
    endtask

    // Mostly full-range values, with the extremes picked out often
    function automatic logic [POS_W-1:0] pick16();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return POS_W'($urandom());
        endcase
    endfunction

    // Random command, weighted toward moves followed by a run of ticks.
    // Fields a command ignores still carry random bits.
    function automatic scroll_cmd_t random_cmd();
        scroll_cmd_t c;
        int unsigned r;
        c.tx = pick16();
        c.ty = pick16();
        c.tms = POS_W'($urandom());
        c.val = pick16();
        r = $urandom_range(99);
        if (r < 45)
        begin
            c.op = tsi_pkg::FUNC_TICK;
            if (mir_active)
            begin
                r = $urandom_range(99);
                if (r < 55)
                    c.tms = POS_W'($urandom_range(mir_dur / 4 + 1));
                else if (r < 80)
                    c.tms = POS_W'($urandom_range(mir_dur));
                else if (r < 88)
                    c.tms = tsi_pkg::ELAPSED_MAX;
            end
        end
        else if (r < 57)
        begin
            c.op = tsi_pkg::FUNC_START;
            r = $urandom_range(99);
            // keep most moves short so the ticks reach the end of them
            if (r < 40)
                c.tms = POS_W'($urandom_range(1, 16));
            else if (r < 65)
                c.tms = POS_W'($urandom_range(255));
            else if (r < 75)
                c.tms = '0;
            else if (r < 85)
                c.tms = tsi_pkg::ELAPSED_MAX;
        end
        else if (r < 65)
            c.op = tsi_pkg::FUNC_SET_X;
        else if (r < 73)
            c.op = tsi_pkg::FUNC_SET_Y;
        else if (r < 87)
        begin
            c.op = (r < 80) ? tsi_pkg::FUNC_FINE_X : tsi_pkg::FUNC_FINE_Y;
            // most fine values sit around the clamp window
            if ($urandom_range(3) != 0)
                c.val = POS_W'($signed($urandom_range(12)) - 2);
        end
        else if (r < 92)
            c.op = tsi_pkg::FUNC_RESET;
        else if (r < 95)
            c.op = FUNC_UNUSED;
        else
            c.op = tsi_pkg::FUNC_TICK;
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        scroll_view_t none;
        scroll_cmd_t  c;
        int unsigned  phase;
        int unsigned  n;
        int unsigned  per_phase;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        beat_fixed = 1'b0;
        beat_view = '0;
        gap_pct = 0;
        stall_pct = 0;
        hold_requests = 0;
        idle_cycles = 0;
        mismatches = 0;
        failures = 0;
        cmds_taken = 0;
        results_checked = 0;
        lerp_ticks = 0;
        snap_ticks = 0;
        idle_ticks = 0;
        moves_started = 0;
        mir_px = '0;
        mir_py = '0;
        mir_sx = '0;
        mir_sy = '0;
        mir_gx = '0;
        mir_gy = '0;
        mir_fx = '0;
        mir_fy = '0;
        mir_dur = '0;
        mir_elapsed = '0;
        mir_active = 1'b0;
        none = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table; typed-in results only where they are plain to see
        // tick right after reset finds no move
        add_row(tsi_pkg::FUNC_TICK,   16'h1111, 16'h2222, 16'h0000, 16'h3333, 1,
                view_of(16'h0000, 16'h0000, 0, 0, 0, 0));
        // position extremes
        add_row(tsi_pkg::FUNC_SET_X,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 1,
                view_of(16'h7FFF, 16'h0000, 0, 0, 0, 0));
        add_row(tsi_pkg::FUNC_SET_Y,  16'h0000, 16'h0000, 16'h0000, 16'h8000, 1,
                view_of(16'h7FFF, 16'h8000, 0, 0, 0, 0));
        // fine offset clamps at both ends and just past the top
        add_row(tsi_pkg::FUNC_FINE_X, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 1,
                view_of(16'h7FFF, 16'h8000, 0, 0, 0, 0));
        add_row(tsi_pkg::FUNC_FINE_X, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 1,
                view_of(16'h7FFF, 16'h8000, 7, 0, 0, 0));
        add_row(tsi_pkg::FUNC_FINE_Y, 16'h0000, 16'h0000, 16'h0000, 16'h0005, 1,
                view_of(16'h7FFF, 16'h8000, 7, 5, 0, 0));
        add_row(tsi_pkg::FUNC_FINE_Y, 16'h0000, 16'h0000, 16'h0000, 16'h0008, 1,
                view_of(16'h7FFF, 16'h8000, 7, 7, 0, 0));
        // unused code seven leaves everything alone
        add_row(FUNC_UNUSED,          16'hA5A5, 16'h5A5A, 16'hFFFF, 16'h0001, 1,
                view_of(16'h7FFF, 16'h8000, 7, 7, 0, 0));
        // set x clears only the x fine offset
        add_row(tsi_pkg::FUNC_SET_X,  16'h0000, 16'h0000, 16'h0000, 16'h8000, 1,
                view_of(16'h8000, 16'h8000, 0, 7, 0, 0));
        // start of a full-span move: position holds until the first tick
        add_row(tsi_pkg::FUNC_START,  16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 1,
                view_of(16'h8000, 16'h8000, 0, 7, 1, 0));
        // zero-length tick still rewrites position and clears fine offsets
        add_row(tsi_pkg::FUNC_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 1,
                view_of(16'h8000, 16'h8000, 0, 0, 1, 1));
        add_row(tsi_pkg::FUNC_TICK,   16'h0000, 16'h0000, 16'd1000, 16'h0000, 0, none);
        // set and fine during a move; the next tick overwrites them
        add_row(tsi_pkg::FUNC_SET_Y,  16'h0000, 16'h0000, 16'h0000, 16'd100,  0, none);
        add_row(tsi_pkg::FUNC_FINE_X, 16'h0000, 16'h0000, 16'h0000, 16'h0003, 0, none);
        add_row(tsi_pkg::FUNC_TICK,   16'h0000, 16'h0000, 16'd20000, 16'h0000, 0, none);
        // elapsed saturates and the move snaps to its goal
        add_row(tsi_pkg::FUNC_TICK,   16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 1,
                view_of(16'h7FFF, 16'h8000, 0, 0, 0, 1));
        add_row(tsi_pkg::FUNC_TICK,   16'h0000, 16'h0000, 16'h0005, 16'h0000, 1,
                view_of(16'h7FFF, 16'h8000, 0, 0, 0, 0));
        // zero duration: first tick snaps without a division
        add_row(tsi_pkg::FUNC_START,  16'h1234, 16'hFFFF, 16'h0000, 16'h0000, 0, none);
        add_row(tsi_pkg::FUNC_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 1,
                view_of(16'h1234, 16'hFFFF, 0, 0, 0, 1));
        // negative span: truncation toward zero
        add_row(tsi_pkg::FUNC_SET_X,  16'h0000, 16'h0000, 16'h0000, 16'd1000, 0, none);
        add_row(tsi_pkg::FUNC_START,  16'hFC18, 16'h0050, 16'h0003, 16'h0000, 0, none);
        add_row(tsi_pkg::FUNC_TICK,   16'h0000, 16'h0000, 16'h0001, 16'h0000, 0, none);
        add_row(tsi_pkg::FUNC_TICK,   16'h0000, 16'h0000, 16'h0001, 16'h0000, 0, none);
        // two large ticks saturate elapsed on a maximal move
        add_row(tsi_pkg::FUNC_START,  16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 0, none);
        add_row(tsi_pkg::FUNC_TICK,   16'h0000, 16'h0000, 16'd65000, 16'h0000, 0, none);
        add_row(tsi_pkg::FUNC_TICK,   16'h0000, 16'h0000, 16'd65000, 16'h0000, 1,
                view_of(16'h8000, 16'h7FFF, 0, 0, 0, 1));
        // reset in the middle of a move, then a tick that finds nothing
        add_row(tsi_pkg::FUNC_START,  16'h4000, 16'hC000, 16'h0100, 16'h0000, 0, none);
        add_row(tsi_pkg::FUNC_RESET,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1,
                view_of(16'h0000, 16'h0000, 0, 0, 0, 0));
        add_row(tsi_pkg::FUNC_TICK,   16'h0000, 16'h0000, 16'h0009, 16'h0000, 1,
                view_of(16'h0000, 16'h0000, 0, 0, 0, 0));

        foreach (cmd_table[i])
            send_cmd(cmd_table[i].cmd, cmd_table[i].fixed, cmd_table[i].view);
        drain_results();

        // Random part in four pressure phases, draining between them
        per_phase = RANDOM_ITEMS / 4;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    gap_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct = 47;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct = 0;
                    stall_pct = 47;
                end
                default:
                begin
                    gap_pct = 37;
                    stall_pct = 37;
                end
            endcase
            for (n = 0; n < per_phase; n++)
            begin
                // one long receiver hold-off while the sender keeps offering
                if (phase == 0 && n == 100)
                    hold_requests++;
                c = random_cmd();
                send_cmd(c, 1'b0, none);
            end
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (view_queue.size() != 0)
        begin
            failures++;
            $display("%0d expected results never arrived", view_queue.size());
        end

        $display("covered %0d commands and %0d checked results over four pressure phases",
                 cmds_taken, results_checked);
        $display("moves started %0d, interpolating ticks %0d, snaps %0d, idle ticks %0d",
                 moves_started, lerp_ticks, snap_ticks, idle_ticks);
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
